// ===== src/pfx_pkg.sv =====
// Shared definitions for the postfix expression evaluator.
// Holds stack sizing, symbol codes, operator codes and the divider interface types.
// Depends on nothing; every other file of the block imports it.
package pfx_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_TIMES = 8'h2A;
  localparam logic [7:0] SYM_SLASH = 8'h2F;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              div_zero;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/pfx_div.sv =====
// Iterative signed divider that truncates towards zero, one quotient bit per cycle.
// A zero divisor gives a zero quotient and raises div_zero in the cycle after start.
// Depends on pfx_pkg for the request and response types.
module pfx_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfx_pkg::div_req_t req_i,
  output pfx_pkg::div_rsp_t rsp_o
);
  import pfx_pkg::*;

  logic                 busy_q;
  logic                 fin_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]    rem_q;
  logic [DATA_W-1:0]    quo_q;
  logic [DATA_W-1:0]    dvs_q;
  logic                 neg_q;
  logic                 dz_q;
  logic [DATA_W-1:0]    res_q;

  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;
  logic                 ge;
  logic [DATA_W-1:0]    rem_d;
  logic [DATA_W-1:0]    quo_d;
  logic                 dvd_neg;
  logic                 dvs_neg;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[DATA_W];
  assign rem_d   = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
  assign quo_d   = {quo_q[DATA_W-2:0], ge};
  assign dvd_neg = req_i.dividend[DATA_W-1];
  assign dvs_neg = req_i.divisor[DATA_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (req_i.start) begin
        done_q <= (req_i.divisor == '0);
        if (req_i.divisor != '0) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        done_q <= 1'b0;
        cnt_q  <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= dvd_neg ? ('0 - req_i.dividend) : req_i.dividend;
      dvs_q <= dvs_neg ? ('0 - req_i.divisor) : req_i.divisor;
      neg_q <= dvd_neg ^ dvs_neg;
      dz_q  <= (req_i.divisor == '0);
      res_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end else if (fin_q) begin
      res_q <= neg_q ? ('0 - quo_q) : quo_q;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.div_zero = dz_q;
  assign rsp_o.quotient = res_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q && !fin_q)
    else $error("divider started while a division is in progress");

  a_busy_fin_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && fin_q))
    else $error("divider iterating and finishing at once");

  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held for more than one cycle");

endmodule

// ===== src/postfix_expression_evaluator.sv =====
// Top level of the postfix expression evaluator: operand stack in a synchronous memory.
// Sequences pops, arithmetic and pushes; uses pfx_pkg and the iterative divider pfx_div.
//
// Usage: symbol beats arrive on the input channel (symbol_i, last_i) under in_valid_i and
// in_stall_o. A digit byte is pushed as it is accepted. An operator pops both operands,
// computes and pushes the result (POPB, POPA, CALC, PUSH); a division waits in S_DIV
// between CALC and PUSH for the 32-step iterative divider, which a zero divisor ends
// without iterating. The next beat is taken only when the current one has finished,
// since it depends on the stack it leaves. A beat with last_i set then reads the top of
// stack from the memory in S_TOP, loads the result beat (value_o and the four flags) into
// the output register in S_EMIT, clears the stack and sticky flags, and returns to idle.
// The output register frees the input side while a result waits; only a second last beat
// waits for the receiver, while out_stall_i holds the earlier result in place.
// Reset empties the stack, clears the flags and drops any pending result; the stack memory
// itself needs no clearing.
module postfix_expression_evaluator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        symbol_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pfx_pkg::DATA_W-1:0] value_o,
  output logic                              underflow_o,
  output logic                              overflow_o,
  output logic                              divide_by_zero_o,
  output logic                              empty_at_end_o
);
  import pfx_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_POPB = 8'b0000_0010,
    S_POPA = 8'b0000_0100,
    S_CALC = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_PUSH = 8'b0010_0000,
    S_TOP  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic              under_q;
  logic              over_q;
  logic              dz_q;
  logic              pop_ok_q;
  logic              out_valid_q;

  op_e               op_q;
  logic              last_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] res_q;
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] value_q;
  logic              underflow_q;
  logic              overflow_q;
  logic              div_zero_q;
  logic              empty_q;

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic              in_acc;
  logic              is_op;
  op_e               op_dec;
  logic [DATA_W-1:0] operand_val;
  logic              has_room;
  logic              not_empty;
  logic [CNT_W-1:0]  cnt_m1;
  logic [DATA_W-1:0] pop_val;
  logic              out_free;
  logic              out_load;
  logic              mem_we;
  logic              mem_re;
  logic [DATA_W-1:0] mem_wd;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign operand_val = {{(DATA_W - 8){1'b0}}, symbol_i} - {{(DATA_W - 8){1'b0}}, SYM_ZERO};
  assign has_room    = (count_q < CNT_W'(STACK_DEPTH));
  assign not_empty   = (count_q != '0);
  assign cnt_m1      = count_q - CNT_W'(1);
  assign pop_val     = pop_ok_q ? rd_q : EMPTY_VALUE;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_EMIT) && out_free;

  always_comb begin
    is_op  = 1'b1;
    op_dec = OP_ADD;
    case (symbol_i)
      SYM_PLUS:  op_dec = OP_ADD;
      SYM_MINUS: op_dec = OP_SUB;
      SYM_TIMES: op_dec = OP_MUL;
      SYM_SLASH: op_dec = OP_DIV;
      default:   is_op  = 1'b0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wd = res_q;
    case (state_q)
      S_IDLE: begin
        mem_we = in_acc && !is_op && has_room;
        mem_wd = operand_val;
      end
      S_POPB, S_POPA, S_TOP: mem_re = not_empty;
      S_PUSH:                mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[PTR_W-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[cnt_m1[PTR_W-1:0]];
    end
  end

  assign div_req.start    = (state_q == S_CALC) && (op_q == OP_DIV);
  assign div_req.dividend = pop_val;
  assign div_req.divisor  = b_q;

  pfx_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      under_q     <= 1'b0;
      over_q      <= 1'b0;
      dz_q        <= 1'b0;
      pop_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (is_op) begin
              state_q <= S_POPB;
            end else begin
              if (has_room) begin
                count_q <= count_q + CNT_W'(1);
              end else begin
                over_q <= 1'b1;
              end
              if (last_i) begin
                state_q <= S_TOP;
              end
            end
          end
        end
        S_POPB, S_POPA: begin
          pop_ok_q <= not_empty;
          if (not_empty) begin
            count_q <= cnt_m1;
          end else begin
            under_q <= 1'b1;
          end
          state_q <= (state_q == S_POPB) ? S_POPA : S_CALC;
        end
        S_CALC: begin
          state_q <= (op_q == OP_DIV) ? S_DIV : S_PUSH;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.div_zero) begin
              dz_q <= 1'b1;
            end
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          count_q <= count_q + CNT_W'(1);
          state_q <= last_q ? S_TOP : S_IDLE;
        end
        S_TOP: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            count_q     <= '0;
            under_q     <= 1'b0;
            over_q      <= 1'b0;
            dz_q        <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_dec;
      last_q <= last_i;
    end
    if (state_q == S_POPA) begin
      b_q <= pop_val;
    end
    if (state_q == S_CALC) begin
      case (op_q)
        OP_ADD:  res_q <= pop_val + b_q;
        OP_SUB:  res_q <= pop_val - b_q;
        OP_MUL:  res_q <= pop_val * b_q;
        default: res_q <= res_q;
      endcase
    end
    if ((state_q == S_DIV) && div_rsp.done) begin
      res_q <= div_rsp.quotient;
    end
    if (out_load) begin
      value_q     <= not_empty ? rd_q : EMPTY_VALUE;
      underflow_q <= under_q;
      overflow_q  <= over_q;
      div_zero_q  <= dz_q;
      empty_q     <= !not_empty;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = value_q;
  assign underflow_o      = underflow_q;
  assign overflow_o       = overflow_q;
  assign divide_by_zero_o = div_zero_q;
  assign empty_at_end_o   = empty_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> has_room)
    else $error("operator result pushed onto a full stack");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider finished while no division was awaited");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (count_q == '0) && !under_q && !over_q && !dz_q)
    else $error("result beat did not clear the stack and flags");

endmodule
